[rtl/core/drt_pkg.sv]
package drt_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } drt_op_t;

    // Register window index, offset[4:2]
    localparam logic [2:0] REG_CTRL0  = 3'd0;
    localparam logic [2:0] REG_COUNT0 = 3'd1;
    localparam logic [2:0] REG_CTRL1  = 3'd2;
    localparam logic [2:0] REG_COUNT1 = 3'd3;
    localparam logic [2:0] REG_USEC   = 3'd4;
    localparam logic [2:0] REG_SEC    = 3'd5;

    localparam int unsigned NUM_TIMERS = 2;
    localparam int unsigned EN_BIT     = 31;
    localparam int unsigned REP_BIT    = 30;
    localparam int unsigned RELOAD_W   = 29;
    localparam int unsigned DIV_W      = 16;
    localparam int unsigned FRAC_W     = 20;
    localparam int unsigned SEC_W      = 13;

    localparam logic [FRAC_W-1:0] USEC_PER_S_M1 = FRAC_W'(999999);
    localparam logic [SEC_W-1:0]  SEC_MAX       = SEC_W'(4294);

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } drt_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  cpu_pending;
        logic [1:0]  cop_pending;
    } drt_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } drt_mod_stat_t;

endpackage

[rtl/core/drt_phase_mod.sv]
module drt_phase_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [drt_pkg::DIV_W-1:0]  dividend,
    input  logic [drt_pkg::DIV_W-1:0]  divisor,
    output drt_pkg::drt_mod_stat_t     stat,
    output logic [drt_pkg::DIV_W-1:0]  remainder
);
    import drt_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W-1:0] rem_step;

    // one restoring-division bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[DIV_W-1]};
        if (rem_sh >= {1'b0, div_reg})
        begin
            rem_step = DIV_W'(rem_sh - {1'b0, div_reg});
        end
        else
        begin
            rem_step = rem_sh[DIV_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg & ~start & (cnt_reg == '0);
    assign remainder = rem_step;

endmodule

[rtl/core/drt_regs.sv]
module drt_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  drt_pkg::drt_item_t         item,
    input  logic                       cfg_write,
    input  logic [drt_pkg::DIV_W-1:0]  cfg_data,
    input  drt_pkg::drt_mod_stat_t     mod_stat,
    input  logic [drt_pkg::DIV_W-1:0]  mod_rem,
    output logic [drt_pkg::DIV_W-1:0]  phase,
    output drt_pkg::drt_result_t       result
);
    import drt_pkg::*;

    logic [31:0]        ctrl_reg  [NUM_TIMERS];
    logic [31:0]        ctrl_next [NUM_TIMERS];
    logic [31:0]        count_reg [NUM_TIMERS];
    logic [31:0]        count_next[NUM_TIMERS];
    logic [31:0]        usec_reg, usec_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [DIV_W-1:0]   phase_reg, phase_next;
    logic [DIV_W-1:0]   div_reg;
    logic [DIV_W-1:0]   div_eff;
    logic [1:0]         cpu_reg, cpu_next;
    logic [1:0]         cop_reg, cop_next;

    logic [2:0]         idx;
    logic [4:0]         sh;
    logic [31:0]        smask;
    logic [31:0]        lmask;
    logic [31:0]        wval;
    logic [31:0]        rsel;
    logic [31:0]        merged;
    logic [DIV_W:0]     phase_inc;
    logic               step;
    logic [31:0]        cnt_dec;
    logic [RELOAD_W-1:0] reload;

    assign div_eff = (div_reg == '0) ? DIV_W'(1) : div_reg;

    always_comb
    begin
        idx = item.offset[4:2];
        sh  = {item.offset[1:0], 3'b000};
        if (item.access_size == SIZE_BYTE)
        begin
            smask = 32'h0000_00ff;
        end
        else if (item.access_size == SIZE_HALF)
        begin
            smask = 32'h0000_ffff;
        end
        else
        begin
            smask = 32'hffff_ffff;
        end
        lmask = smask << sh;
        wval  = (item.write_data << sh) & lmask;

        unique case (idx)
            REG_CTRL0:  rsel = ctrl_reg[0];
            REG_COUNT0: rsel = count_reg[0];
            REG_CTRL1:  rsel = ctrl_reg[1];
            REG_COUNT1: rsel = count_reg[1];
            REG_USEC:   rsel = usec_reg;
            REG_SEC:    rsel = {{(32-SEC_W){1'b0}}, sec_reg};
            default:    rsel = '0;
        endcase
    end

    always_comb
    begin
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            ctrl_next[t]  = ctrl_reg[t];
            count_next[t] = count_reg[t];
        end
        usec_next  = usec_reg;
        frac_next  = frac_reg;
        sec_next   = sec_reg;
        phase_next = phase_reg;
        cpu_next   = cpu_reg;
        cop_next   = cop_reg;
        result.read_data = '0;
        phase_inc = {1'b0, phase_reg} + 1'b1;
        step      = (phase_inc == {1'b0, div_eff});
        merged    = '0;
        cnt_dec   = '0;
        reload    = '0;

        if (mod_stat.done)
        begin
            phase_next = mod_rem;
        end

        if (go)
        begin
            unique case (item.operation)
                OP_READ:
                begin
                    result.read_data = (rsel >> sh) & smask;
                    if (idx == REG_COUNT0)
                    begin
                        cpu_next[0] = 1'b0;
                        cop_next[0] = 1'b0;
                    end
                    if (idx == REG_COUNT1)
                    begin
                        cpu_next[1] = 1'b0;
                        cop_next[1] = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    for (int t = 0; t < NUM_TIMERS; t++)
                    begin
                        if (idx[2:1] == 2'(t) && !idx[0])
                        begin
                            merged = (ctrl_reg[t] & ~lmask) | wval;
                            ctrl_next[t] = merged;
                            if (merged[EN_BIT] && !ctrl_reg[t][EN_BIT])
                            begin
                                count_next[t] = {{(32-RELOAD_W){1'b0}},
                                                 merged[RELOAD_W-1:0]};
                            end
                        end
                        if (idx[2:1] == 2'(t) && idx[0])
                        begin
                            count_next[t] = (count_reg[t] & ~lmask) | wval;
                        end
                    end
                end
                OP_TICK:
                begin
                    usec_next = usec_reg + 1'b1;
                    if (usec_reg == 32'hffff_ffff)
                    begin
                        frac_next = '0;
                        sec_next  = '0;
                    end
                    else if (frac_reg == USEC_PER_S_M1)
                    begin
                        frac_next = '0;
                        sec_next  = sec_reg + 1'b1;
                    end
                    else
                    begin
                        frac_next = frac_reg + 1'b1;
                    end
                    phase_next = step ? '0 : phase_inc[DIV_W-1:0];
                    if (step)
                    begin
                        for (int t = 0; t < NUM_TIMERS; t++)
                        begin
                            reload  = ctrl_reg[t][RELOAD_W-1:0];
                            cnt_dec = count_reg[t] - 1'b1;
                            if (ctrl_reg[t][EN_BIT] && reload != '0 && count_reg[t] != '0)
                            begin
                                count_next[t] = cnt_dec;
                                if (cnt_dec == '0)
                                begin
                                    cpu_next[t] = 1'b1;
                                    cop_next[t] = 1'b1;
                                    if (ctrl_reg[t][REP_BIT])
                                    begin
                                        count_next[t] = {{(32-RELOAD_W){1'b0}}, reload};
                                    end
                                    else
                                    begin
                                        ctrl_next[t][EN_BIT] = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        result.cpu_pending = cpu_next;
        result.cop_pending = cop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                ctrl_reg[t]  <= '0;
                count_reg[t] <= '0;
            end
            usec_reg  <= '0;
            frac_reg  <= '0;
            sec_reg   <= '0;
            phase_reg <= '0;
            div_reg   <= DIV_W'(1);
            cpu_reg   <= '0;
            cop_reg   <= '0;
        end
        else
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                ctrl_reg[t]  <= ctrl_next[t];
                count_reg[t] <= count_next[t];
            end
            usec_reg  <= usec_next;
            frac_reg  <= frac_next;
            sec_reg   <= sec_next;
            phase_reg <= phase_next;
            cpu_reg   <= cpu_next;
            cop_reg   <= cop_next;
            if (cfg_write)
            begin
                div_reg <= cfg_data;
            end
        end
    end

    assign phase = phase_reg;

    // CPU and coprocessor copies are set and cleared together
    a_pend_match: assert property (@(posedge clk) disable iff (!rst_n)
        cpu_reg == cop_reg)
        else $error("cpu/cop pending bits diverged");

    // seconds split stays in range
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg <= USEC_PER_S_M1 && sec_reg <= SEC_MAX)
        else $error("seconds counter out of range");

    // phase is reduced below the divider whenever no rescale is running
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        !mod_stat.busy && !$past(cfg_write) |-> phase_reg < div_eff)
        else $error("prescale phase not below divider");

endmodule

[rtl/core/dual_reload_timer_device.sv]
// Dual reload timer: two down-counting timers behind a 32-byte register
// window, plus a free-running microsecond counter and its seconds view.
// Each input beat is a bus read, a bus write or one tick; each produces
// exactly one result beat carrying the read data (zero unless a read) and
// the CPU/coprocessor pending bits after that beat. A beat flows through an
// input register and then the result register, and a new beat is taken
// every cycle while the result side keeps up and no rescale is running.
// Writing the divider (cfg_write) starts a rescale of the prescaler phase
// (one remainder bit per cycle in the phase divider); item_stall is held
// while it runs, starting the cycle after the write. Seconds are kept as an
// incremental seconds / sub-second pair stepped with the microsecond
// counter, so reads of 0x14 cost no divide.
module dual_reload_timer_device (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  drt_pkg::drt_item_t         item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output drt_pkg::drt_result_t       result,
    input  logic                       cfg_write,
    input  logic [drt_pkg::DIV_W-1:0]  cfg_data
);
    import drt_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    drt_item_t        s1_item_reg;
    logic             out_valid_reg, out_valid_next;
    drt_result_t      out_reg;
    drt_result_t      res;
    logic             advance;
    logic             accept;
    drt_mod_stat_t    mod_stat;
    logic [DIV_W-1:0] mod_rem;
    logic [DIV_W-1:0] phase;
    logic [DIV_W-1:0] cfg_div_eff;

    // input register moves into the result register when the latter is free and no rescale is running
    assign advance    = s1_valid_reg & ~mod_stat.busy & (~out_valid_reg | ~result_stall);
    assign item_stall = mod_stat.busy | (s1_valid_reg & ~advance);
    assign accept     = item_valid & ~item_stall;

    assign cfg_div_eff = (cfg_data == '0) ? DIV_W'(1) : cfg_data;

    always_comb
    begin
        s1_valid_next  = accept | (s1_valid_reg & ~advance);
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    // phase rescale after a divider write: phase mod new divider
    drt_phase_mod u_phase_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_write),
        .dividend  (phase),
        .divisor   (cfg_div_eff),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    // timer state, register window and per-beat result
    drt_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (advance),
        .item      (s1_item_reg),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .mod_stat  (mod_stat),
        .mod_rem   (mod_rem),
        .phase     (phase),
        .result    (res)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // no beat enters the timer logic during a phase rescale
    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.busy |-> !advance)
        else $error("beat processed during rescale");

    // an accepted beat always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost");

    // a result held under stall is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |-> !advance)
        else $error("result overwritten under stall");

endmodule
